>>> design/cdiv_pkg.sv
// Shared types and constants for the complex divider.
// Depends on nothing; every other file in the design imports it.
package cdiv_pkg;

  localparam int IN_W     = 16;            // operand width, two's complement
  localparam int OUT_FRAC = 16;            // fraction bits of the quotient
  localparam int Q_W      = 32;            // quotient width
  localparam int NUM_W    = 2 * IN_W + 1;  // signed numerator sum
  localparam int MAG_W    = 2 * IN_W;      // numerator magnitude
  localparam int DEN_W    = 2 * IN_W;      // denominator, unsigned
  localparam int HEAD_SH  = Q_W - OUT_FRAC;
  localparam int CMP_W    = DEN_W + HEAD_SH;
  localparam int FRONT_LAT = 2;
  localparam int LANE_LAT  = Q_W + 2;

  typedef struct packed {
    logic signed [IN_W-1:0] dividend_real;
    logic signed [IN_W-1:0] dividend_imag;
    logic signed [IN_W-1:0] divisor_real;
    logic signed [IN_W-1:0] divisor_imag;
  } in_beat_t;

  typedef struct packed {
    logic signed [Q_W-1:0] quotient_real;
    logic signed [Q_W-1:0] quotient_imag;
    logic                  divide_by_zero;
    logic                  saturated;
  } out_beat_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           neg;
    logic           ovf;
  } lane_res_t;

endpackage

>>> design/complex_divider.sv
// Top level of the complex divider: front end, two quotient lanes, result
// clamp and output register. Uses cdiv_pkg, cdiv_front and cdiv_lane.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   cdiv_pkg::in_beat_t
//   out_     output     out_valid / out_stall cdiv_pkg::out_beat_t
//
// One beat enters per cycle while in_stall is low; the long part of the
// pipeline is the bit-serial divide, one quotient bit per pipeline stage in
// each lane.
// Reset (rst_n low at a clock edge) clears only the valid bits.
// When the output register holds a beat that is stalled, the whole pipeline
// freezes and in_stall is raised; nothing is dropped or repeated.
module complex_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cdiv_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cdiv_pkg::out_beat_t  out_data
);
  import cdiv_pkg::*;

  localparam int PIPE_D = FRONT_LAT + LANE_LAT;

  logic                    en;
  logic signed [NUM_W-1:0] num1, num2;
  logic        [DEN_W-1:0] den;
  lane_res_t               res_re, res_im;

  logic v_r  [0:PIPE_D-1];
  logic dz_r [0:LANE_LAT-1];
  logic      out_valid_r;
  out_beat_t out_data_r, out_data_nxt;

  logic [Q_W-1:0] val_re, val_im;
  logic           sat_re, sat_im;

  // The pipeline moves whenever the output register can take a new beat.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  cdiv_front u_front (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .num1    (num1),
    .num2    (num2),
    .den     (den)
  );

  cdiv_lane u_lane_re (.clk(clk), .en(en), .num(num1), .den(den), .res(res_re));
  cdiv_lane u_lane_im (.clk(clk), .en(en), .num(num2), .den(den), .res(res_im));

  // Valid bits run beside the data; the zero-divisor flag joins them where
  // the denominator enters the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_D; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < PIPE_D; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz_r[0] <= (den == '0);
      for (int i = 1; i < LANE_LAT; i++) dz_r[i] <= dz_r[i-1];
    end
  end

  // Clamp each lane to the signed range and restore the sign. A negative
  // quotient may reach 2^(Q_W-1); a positive one stops one below.
  function automatic logic [Q_W:0] clamp_q(input lane_res_t r);
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] mag;
    logic           sat;
    lim = r.neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    sat = r.ovf || (r.q > lim);
    mag = sat ? lim : r.q;
    return {sat, r.neg ? (~mag + 1'b1) : mag};
  endfunction

  always_comb begin
    {sat_re, val_re} = clamp_q(res_re);
    {sat_im, val_im} = clamp_q(res_im);
    if (dz_r[LANE_LAT-1]) begin
      out_data_nxt.quotient_real  = '0;
      out_data_nxt.quotient_imag  = '0;
      out_data_nxt.divide_by_zero = 1'b1;
      out_data_nxt.saturated      = 1'b0;
    end else begin
      out_data_nxt.quotient_real  = val_re;
      out_data_nxt.quotient_imag  = val_im;
      out_data_nxt.divide_by_zero = 1'b0;
      out_data_nxt.saturated      = sat_re || sat_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[PIPE_D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/cdiv_front.sv
// Front end of the complex divider: six products, then the two numerators
// and the denominator. Two register stages. Uses cdiv_pkg.
module cdiv_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  cdiv_pkg::in_beat_t                   in_data,
  output logic signed [cdiv_pkg::NUM_W-1:0]    num1,
  output logic signed [cdiv_pkg::NUM_W-1:0]    num2,
  output logic        [cdiv_pkg::DEN_W-1:0]    den
);
  import cdiv_pkg::*;

  logic signed [2*IN_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, d_rr_r, d_ii_r;
  logic signed [NUM_W-1:0]  num1_r, num2_r;
  logic        [DEN_W-1:0]  den_r;

  // Stage one: products.
  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r <= in_data.dividend_real * in_data.divisor_real;
      p_ii_r <= in_data.dividend_imag * in_data.divisor_imag;
      p_ir_r <= in_data.dividend_imag * in_data.divisor_real;
      p_ri_r <= in_data.dividend_real * in_data.divisor_imag;
      d_rr_r <= in_data.divisor_real  * in_data.divisor_real;
      d_ii_r <= in_data.divisor_imag  * in_data.divisor_imag;
    end
  end

  // Stage two: sums. Squares are never negative, so the denominator is
  // taken unsigned; it never exceeds 2^(2*IN_W-1).
  always_ff @(posedge clk) begin
    if (en) begin
      num1_r <= NUM_W'(p_rr_r) + NUM_W'(p_ii_r);
      num2_r <= NUM_W'(p_ir_r) - NUM_W'(p_ri_r);
      den_r  <= DEN_W'(d_rr_r) + DEN_W'(d_ii_r);
    end
  end

  assign num1 = num1_r;
  assign num2 = num2_r;
  assign den  = den_r;

endmodule

>>> design/cdiv_lane.sv
// One quotient lane: sign split, overflow test, then one restoring
// division step per stage for each of the Q_W quotient bits. Uses cdiv_pkg.
module cdiv_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [cdiv_pkg::NUM_W-1:0]  num,
  input  logic        [cdiv_pkg::DEN_W-1:0]  den,
  output cdiv_pkg::lane_res_t                res
);
  import cdiv_pkg::*;

  logic [MAG_W-1:0] mag_r;
  logic             neg0_r;
  logic [DEN_W-1:0] den0_r;

  logic [DEN_W-1:0] rem_r  [0:Q_W];
  logic [DEN_W-1:0] dpipe_r[0:Q_W];
  logic [Q_W-1:0]   low_r  [0:Q_W];
  logic [Q_W-1:0]   q_r    [0:Q_W];
  logic             neg_r  [0:Q_W];
  logic             ovf_r  [0:Q_W];

  logic [MAG_W-1:0]   mag_nxt;
  logic [CMP_W-1:0]   den_sh;
  logic [Q_W-1:0]     low_ext;

  always_comb begin
    mag_nxt = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    den_sh  = CMP_W'(den0_r) << HEAD_SH;
    low_ext = Q_W'(mag_r) << OUT_FRAC;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      neg0_r <= num[NUM_W-1];
      den0_r <= den;
    end
  end

  // The quotient fits Q_W bits exactly when mag < den * 2^HEAD_SH; then the
  // bits of mag above the low Q_W bits of mag*2^OUT_FRAC are a remainder
  // already below den.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0]   <= CMP_W'(mag_r) >= den_sh;
      rem_r[0]   <= DEN_W'(mag_r >> HEAD_SH);
      low_r[0]   <= low_ext;
      dpipe_r[0] <= den0_r;
      q_r[0]     <= '0;
      neg_r[0]   <= neg0_r;
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [DEN_W:0] remx;
    logic           take;
    always_comb begin
      remx = {rem_r[s], low_r[s][Q_W-1]};
      take = remx >= {1'b0, dpipe_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]   <= take ? DEN_W'(remx - {1'b0, dpipe_r[s]}) : DEN_W'(remx);
        q_r[s+1]     <= {q_r[s][Q_W-2:0], take};
        low_r[s+1]   <= {low_r[s][Q_W-2:0], 1'b0};
        dpipe_r[s+1] <= dpipe_r[s];
        neg_r[s+1]   <= neg_r[s];
        ovf_r[s+1]   <= ovf_r[s];
      end
    end
  end

  assign res.q   = q_r[Q_W];
  assign res.neg = neg_r[Q_W];
  assign res.ovf = ovf_r[Q_W];

endmodule

>>> tb/tb_complex_divider.sv
// Testbench for complex_divider: directed table plus random operand beats,
// each result checked against a bit-exact quotient predictor. Uses cdiv_pkg.
module tb_complex_divider;
  import cdiv_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RAND_BEATS = 1750;
  localparam int DRAIN_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;

  complex_divider uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Quotients that are still in flight, oldest first.
  out_beat_t pending_quotients[$];
  int err_count;
  bit stim_done;
  longint cycle_count;

  // Truncated, saturated num * 2^OUT_FRAC / den for den > 0. The numerator is
  // at most 2^31 in magnitude, so 64-bit arithmetic is exact here.
  function automatic logic [Q_W-1:0] scaled_quotient(
      input longint num, input longint den, inout logic sat);
    longint mag;
    longint q;
    longint lim;
    mag = (num < 0) ? -num : num;
    q = (mag <<< OUT_FRAC) / den;
    lim = (num < 0) ? 64'sd2147483648 : 64'sd2147483647;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    if (num < 0) q = -q;
    return q[Q_W-1:0];
  endfunction

  function automatic out_beat_t divide_complex(input in_beat_t b);
    out_beat_t r;
    longint ar, ai, br, bi, den;
    logic sat;
    ar = b.dividend_real;
    ai = b.dividend_imag;
    br = b.divisor_real;
    bi = b.divisor_imag;
    den = br * br + bi * bi;
    sat = 1'b0;
    r = '0;
    if (den == 0) begin
      r.divide_by_zero = 1'b1;
    end else begin
      r.quotient_real = scaled_quotient(ar * br + ai * bi, den, sat);
      r.quotient_imag = scaled_quotient(ai * br - ar * bi, den, sat);
      r.saturated = sat;
    end
    return r;
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Drives one beat and holds it until the block accepts it. The valid stays
  // high across back-to-back beats so it is never dropped and raised in one step.
  task automatic send_beat(input in_beat_t b, input bit check_typed,
                           input out_beat_t typed);
    int gap;
    out_beat_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    predicted = divide_complex(b);
    if (check_typed && predicted !== typed) begin
      $error("table row mismatch: typed %h predicted %h", typed, predicted);
      err_count++;
    end
    pending_quotients.insert(pending_quotients.size(),
                             check_typed ? typed : predicted);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] rand_operand();
    int roll;
    roll = $urandom_range(9);
    case (roll)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return IN_W'($urandom_range(3) - 1);
      default: return IN_W'($urandom());
    endcase
  endfunction

  // Directed rows: operands, whether the result is typed in, and that result.
  typedef struct {
    in_beat_t  stim;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  dir_row_t dir_table[] = '{
    '{'{16'sh1000, 16'sh0000, 16'sh0000, 16'sh0000}, 1, '{0, 0, 1'b1, 1'b0}},
    '{'{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000}, 1, '{0, 0, 1'b1, 1'b0}},
    '{'{16'sh1000, 16'sh0000, 16'sh1000, 16'sh0000}, 1,
      '{32'sh0001_0000, 0, 1'b0, 1'b0}},
    '{'{16'sh0000, 16'sh1000, 16'sh1000, 16'sh0000}, 1,
      '{0, 32'sh0001_0000, 1'b0, 1'b0}},
    // Largest dividend over the smallest divisor: both parts stay in range,
    // the negative one landing exactly on the most negative quotient.
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh0000}, 1,
      '{32'sh7FFF_0000, 32'sh7FFF_0000, 1'b0, 1'b0}},
    '{'{16'sh8000, 16'sh8000, 16'sh0001, 16'sh0000}, 1,
      '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0}},
    '{'{16'sh8000, 16'sh0000, 16'sh0000, 16'sh0001}, 1,
      '{32'sh0000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b1}},
    '{'{16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000}, 1, '{0, 0, 1'b0, 1'b0}},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 0, '{0, 0, 0, 0}},
    '{'{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}, 0, '{0, 0, 0, 0}},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0, '{0, 0, 0, 0}},
    '{'{16'shFFFF, 16'sh0001, 16'sh0003, 16'shFFFD}, 0, '{0, 0, 0, 0}},
    '{'{16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh0000}, 0, '{0, 0, 0, 0}},
    '{'{16'sh1234, 16'shEDCB, 16'sh0100, 16'shFF00}, 0, '{0, 0, 0, 0}},
    '{'{16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555}, 0, '{0, 0, 0, 0}}
  };

  // Stimulus: reset, the directed table, then random beats.
  initial begin
    in_beat_t b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    err_count = 0;
    stim_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_table[i])
      send_beat(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);
    for (int n = 0; n < RAND_BEATS; n++) begin
      b.dividend_real = rand_operand();
      b.dividend_imag = rand_operand();
      b.divisor_real = rand_operand();
      b.divisor_imag = rand_operand();
      send_beat(b, 1'b0, '0);
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // The result side stalls at random, with the same gap profile.
  initial begin
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      hold = pick_gap();
      if (hold == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Each accepted result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_quotients.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        err_count++;
      end else begin
        want = pending_quotients.pop_front();
        if (out_data.quotient_real !== want.quotient_real) begin
          $error("quotient_real expected %h actual %h",
                 want.quotient_real, out_data.quotient_real);
          err_count++;
        end
        if (out_data.quotient_imag !== want.quotient_imag) begin
          $error("quotient_imag expected %h actual %h",
                 want.quotient_imag, out_data.quotient_imag);
          err_count++;
        end
        if (out_data.divide_by_zero !== want.divide_by_zero) begin
          $error("divide_by_zero expected %b actual %b",
                 want.divide_by_zero, out_data.divide_by_zero);
          err_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b",
                 want.saturated, out_data.saturated);
          err_count++;
        end
      end
    end
  end

  // End of run: drain, allow stray beats to surface, then report. The cycle
  // limit covers the worst case of long gaps on both sides plus pipeline depth.
  initial begin
    cycle_count = 0;
    fork
      begin
        wait (stim_done);
        while (pending_quotients.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        err_count++;
        $error("timeout with %0d results outstanding", pending_quotients.size());
      end
    join_any
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
